/* sv/gble_pkg.sv */
// ----------------------------------------------------------------------------
// gble_pkg
// Shared types and constants for the gap buffer line editor.
// ----------------------------------------------------------------------------
package gble_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int CHAR_W        = 8;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [CHAR_W-1:0] CURSOR_LEFT_RESET  = 8'd60;
    localparam logic [CHAR_W-1:0] CURSOR_RIGHT_RESET = 8'd62;
    localparam logic [CHAR_W-1:0] DELETE_RESET       = 8'd45;

    localparam logic [CFG_INDEX_W-1:0] REG_CURSOR_LEFT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CURSOR_RIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DELETE       = 2'd2;

    localparam logic CMD_KEY   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DRAIN
    } state_t;

endpackage

/* sv/gble_cell.sv */
// ----------------------------------------------------------------------------
// gble_cell
// One character slot of a stack; takes its neighbor's byte on push or pop.
// ----------------------------------------------------------------------------
module gble_cell (
    input  logic                       aclk,
    input  gble_pkg::cell_op_t         op,
    input  logic [gble_pkg::CHAR_W-1:0] near_data,
    input  logic [gble_pkg::CHAR_W-1:0] far_data,
    output logic [gble_pkg::CHAR_W-1:0] q
);

    logic [gble_pkg::CHAR_W-1:0] q_reg;
    logic [gble_pkg::CHAR_W-1:0] q_next;

    always_comb begin
        case (op)
            gble_pkg::CELL_PUSH: q_next = near_data;
            gble_pkg::CELL_POP:  q_next = far_data;
            default:             q_next = q_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

/* sv/gble_stack.sv */
// ----------------------------------------------------------------------------
// gble_stack
// A row of cells forming a shift stack; cell zero is the top of the stack.
// ----------------------------------------------------------------------------
module gble_stack #(
    parameter int DEPTH = gble_pkg::LINE_CAPACITY
) (
    input  logic                        aclk,
    input  gble_pkg::cell_op_t          op,
    input  logic [gble_pkg::CHAR_W-1:0] push_data,
    output logic [gble_pkg::CHAR_W-1:0] top_data
);

    logic [gble_pkg::CHAR_W-1:0] cell_q [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [gble_pkg::CHAR_W-1:0] near_data;
        logic [gble_pkg::CHAR_W-1:0] far_data;

        if (i == 0) begin : g_top
            assign near_data = push_data;
        end else begin : g_inner_near
            assign near_data = cell_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_bottom
            assign far_data = '0;
        end else begin : g_inner_far
            assign far_data = cell_q[i+1];
        end

        gble_cell u_cell (
            .aclk      (aclk),
            .op        (op),
            .near_data (near_data),
            .far_data  (far_data),
            .q         (cell_q[i])
        );
    end

    assign top_data = cell_q[0];

endmodule

/* sv/gap_buffer_line_editor_unit.sv */
// ----------------------------------------------------------------------------
// gap_buffer_line_editor_unit
// Line editor with a cursor, kept as two shift stacks of character cells.
// ----------------------------------------------------------------------------
// A keystroke transaction is accepted while the block is idle and moves, drops or
// inserts one character in a single cell-row shift; an insert into a full line
// only sets the overflow flag. A flush transaction first shifts every character
// left of the cursor onto the right stack, one per cycle, then pops the right
// stack into the output register at one character per cycle while the sink
// keeps m_tready high (a single empty beat for an empty line). No input is
// accepted during a flush.
module gap_buffer_line_editor_unit #(
    parameter int LINE_CAPACITY = gble_pkg::LINE_CAPACITY
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // key
    input  logic                             s_tuser,   // command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // out_char
    output logic [1:0]                       m_tuser,   // overflowed, line_empty
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [gble_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gble_pkg::CHAR_W-1:0]      cfg_wr_data
);

    localparam int CNT_W = $clog2(LINE_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W:0]   CAP_SUM = (CNT_W + 1)'(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(LINE_CAPACITY);

    logic [gble_pkg::CHAR_W-1:0] left_code_reg;
    logic [gble_pkg::CHAR_W-1:0] right_code_reg;
    logic [gble_pkg::CHAR_W-1:0] delete_code_reg;

    gble_pkg::state_t state_reg;
    gble_pkg::state_t state_next;

    logic [CNT_W-1:0] left_cnt_reg;
    logic [CNT_W-1:0] left_cnt_next;
    logic [CNT_W-1:0] right_cnt_reg;
    logic [CNT_W-1:0] right_cnt_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             flush_ovf_reg;
    logic             flush_ovf_next;
    logic             flush_empty_reg;
    logic             flush_empty_next;

    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [gble_pkg::CHAR_W-1:0] m_data_reg;
    logic [gble_pkg::CHAR_W-1:0] m_data_next;
    logic                        m_last_reg;
    logic                        m_last_next;
    logic                        m_empty_reg;
    logic                        m_empty_next;
    logic                        m_ovf_reg;
    logic                        m_ovf_next;

    gble_pkg::cell_op_t          left_op;
    gble_pkg::cell_op_t          right_op;
    logic [gble_pkg::CHAR_W-1:0] left_push;
    logic [gble_pkg::CHAR_W-1:0] left_top;
    logic [gble_pkg::CHAR_W-1:0] right_top;

    logic             s_accept;
    logic             out_free;
    logic             emit;
    logic [CNT_W:0]   total;

    assign s_tready = (state_reg == gble_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign total    = {1'b0, left_cnt_reg} + {1'b0, right_cnt_reg};

    gble_stack #(
        .DEPTH (LINE_CAPACITY)
    ) u_left_stack (
        .aclk      (aclk),
        .op        (left_op),
        .push_data (left_push),
        .top_data  (left_top)
    );

    gble_stack #(
        .DEPTH (LINE_CAPACITY)
    ) u_right_stack (
        .aclk      (aclk),
        .op        (right_op),
        .push_data (left_top),
        .top_data  (right_top)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_code_reg   <= gble_pkg::CURSOR_LEFT_RESET;
            right_code_reg  <= gble_pkg::CURSOR_RIGHT_RESET;
            delete_code_reg <= gble_pkg::DELETE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gble_pkg::REG_CURSOR_LEFT:  left_code_reg   <= cfg_wr_data;
                gble_pkg::REG_CURSOR_RIGHT: right_code_reg  <= cfg_wr_data;
                gble_pkg::REG_DELETE:       delete_code_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gble_pkg::ST_IDLE: begin
                if (s_accept && s_tuser == gble_pkg::CMD_FLUSH) begin
                    state_next = (left_cnt_reg != '0) ? gble_pkg::ST_SHIFT
                                                      : gble_pkg::ST_DRAIN;
                end
            end
            gble_pkg::ST_SHIFT: begin
                if (left_cnt_reg == CNT_ONE) begin
                    state_next = gble_pkg::ST_DRAIN;
                end
            end
            gble_pkg::ST_DRAIN: begin
                if (out_free && (flush_empty_reg || right_cnt_reg == CNT_ONE)) begin
                    state_next = gble_pkg::ST_IDLE;
                end
            end
            default: state_next = gble_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        left_op          = gble_pkg::CELL_HOLD;
        right_op         = gble_pkg::CELL_HOLD;
        left_push        = s_tdata;
        left_cnt_next    = left_cnt_reg;
        right_cnt_next   = right_cnt_reg;
        ovf_next         = ovf_reg;
        flush_ovf_next   = flush_ovf_reg;
        flush_empty_next = flush_empty_reg;
        emit             = 1'b0;
        case (state_reg)
            gble_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == gble_pkg::CMD_FLUSH) begin
                        ovf_next         = 1'b0;
                        flush_ovf_next   = ovf_reg;
                        flush_empty_next = (total == '0);
                    end else if (s_tdata == left_code_reg) begin
                        if (left_cnt_reg != '0 && right_cnt_reg < CAP_CNT) begin
                            left_op        = gble_pkg::CELL_POP;
                            right_op       = gble_pkg::CELL_PUSH;
                            left_cnt_next  = left_cnt_reg - CNT_ONE;
                            right_cnt_next = right_cnt_reg + CNT_ONE;
                        end
                    end else if (s_tdata == right_code_reg) begin
                        if (right_cnt_reg != '0 && left_cnt_reg < CAP_CNT) begin
                            left_push      = right_top;
                            left_op        = gble_pkg::CELL_PUSH;
                            right_op       = gble_pkg::CELL_POP;
                            left_cnt_next  = left_cnt_reg + CNT_ONE;
                            right_cnt_next = right_cnt_reg - CNT_ONE;
                        end
                    end else if (s_tdata == delete_code_reg) begin
                        if (left_cnt_reg != '0) begin
                            left_op       = gble_pkg::CELL_POP;
                            left_cnt_next = left_cnt_reg - CNT_ONE;
                        end
                    end else if (total >= CAP_SUM) begin
                        ovf_next = 1'b1;
                    end else begin
                        left_op       = gble_pkg::CELL_PUSH;
                        left_cnt_next = left_cnt_reg + CNT_ONE;
                    end
                end
            end
            gble_pkg::ST_SHIFT: begin
                left_op        = gble_pkg::CELL_POP;
                right_op       = gble_pkg::CELL_PUSH;
                left_cnt_next  = left_cnt_reg - CNT_ONE;
                right_cnt_next = right_cnt_reg + CNT_ONE;
            end
            gble_pkg::ST_DRAIN: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (!flush_empty_reg) begin
                        right_op       = gble_pkg::CELL_POP;
                        right_cnt_next = right_cnt_reg - CNT_ONE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_empty_next = m_empty_reg;
        m_ovf_next   = m_ovf_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = flush_empty_reg ? '0 : right_top;
            m_last_next  = flush_empty_reg || (right_cnt_reg == CNT_ONE);
            m_empty_next = flush_empty_reg;
            m_ovf_next   = flush_ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gble_pkg::ST_IDLE;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
            ovf_reg       <= ovf_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        flush_ovf_reg   <= flush_ovf_next;
        flush_empty_reg <= flush_empty_next;
        m_data_reg      <= m_data_next;
        m_last_reg      <= m_last_next;
        m_empty_reg     <= m_empty_next;
        m_ovf_reg       <= m_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_ovf_reg, m_empty_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        total <= CAP_SUM)
        else $error("Line holds more characters than its capacity.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gble_pkg::ST_DRAIN && state_next == gble_pkg::ST_IDLE)
        |=> (left_cnt_reg == '0 && right_cnt_reg == '0))
        else $error("Buffer not empty at the end of a flush.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gble_pkg::ST_SHIFT) |-> (left_cnt_reg != '0))
        else $error("Shift phase entered with an empty left stack.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == gble_pkg::CMD_FLUSH) |=> !ovf_reg)
        else $error("Overflow flag not cleared by a flush.");

endmodule
